// File: hw/rtl/lpc_pkg.sv
package lpc_pkg;

    // Field widths
    localparam int POT_BITS    = 12;
    localparam int GAIN_BITS   = 10;
    localparam int OFFSET_BITS = 10;
    localparam int MARGIN_BITS = 10;
    localparam int DRIVE_BITS  = 8;

    // Error spans height - pot + offset, two bits above the pot width
    localparam int ERR_BITS  = POT_BITS + 2;
    localparam int PROD_BITS = ERR_BITS + GAIN_BITS;
    localparam int Q_SHIFT   = 8;
    localparam int QUOT_BITS = PROD_BITS - Q_SHIFT;

    localparam int DRIVE_LIMIT = 127;

    // Configuration port
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 12;

    localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_UP       = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_DOWN     = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LEFT_OFFSET   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GROUND_HEIGHT = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOW_HEIGHT    = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MED_HEIGHT    = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HIGH_HEIGHT   = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SAFETY_MARGIN = 3'd7;

    // Register reset values
    localparam logic [GAIN_BITS-1:0]   RST_GAIN_UP       = 10'd154;
    localparam logic [GAIN_BITS-1:0]   RST_GAIN_DOWN     = 10'd51;
    localparam logic [OFFSET_BITS-1:0] RST_LEFT_OFFSET   = 10'd30;
    localparam logic [POT_BITS-1:0]    RST_GROUND_HEIGHT = 12'd550;
    localparam logic [POT_BITS-1:0]    RST_LOW_HEIGHT    = 12'd1300;
    localparam logic [POT_BITS-1:0]    RST_MED_HEIGHT    = 12'd1800;
    localparam logic [POT_BITS-1:0]    RST_HIGH_HEIGHT   = 12'd2500;
    localparam logic [MARGIN_BITS-1:0] RST_SAFETY_MARGIN = 10'd50;

endpackage

// File: hw/rtl/lpc_p_term.sv
// Proportional term for one side: sign-magnitude Q8 multiply,
// truncated toward zero, saturated to the drive limit.
module lpc_p_term
(
    input  logic signed [lpc_pkg::ERR_BITS-1:0]   err,
    input  logic        [lpc_pkg::GAIN_BITS-1:0]  gain_up,
    input  logic        [lpc_pkg::GAIN_BITS-1:0]  gain_down,
    output logic signed [lpc_pkg::DRIVE_BITS-1:0] drive
);

    localparam logic [lpc_pkg::QUOT_BITS-1:0] LIMIT_Q =
        lpc_pkg::QUOT_BITS'(lpc_pkg::DRIVE_LIMIT);

    logic                              positive;
    logic [lpc_pkg::ERR_BITS-1:0]      magnitude;
    logic [lpc_pkg::GAIN_BITS-1:0]     gain;
    logic [lpc_pkg::PROD_BITS-1:0]     product;
    logic [lpc_pkg::QUOT_BITS-1:0]     quotient;
    logic [lpc_pkg::QUOT_BITS-1:0]     bounded;
    logic [lpc_pkg::DRIVE_BITS-1:0]    bounded_narrow;

    // Positive error uses the up gain, zero or negative the down gain
    assign positive  = (err > 0);
    assign magnitude = positive ? err : -err;
    assign gain      = positive ? gain_up : gain_down;

    assign product  = lpc_pkg::PROD_BITS'(magnitude) * lpc_pkg::PROD_BITS'(gain);
    assign quotient = product[lpc_pkg::PROD_BITS-1:lpc_pkg::Q_SHIFT];

    // Saturate the magnitude, then restore the sign
    assign bounded        = (quotient > LIMIT_Q) ? LIMIT_Q : quotient;
    assign bounded_narrow = bounded[lpc_pkg::DRIVE_BITS-1:0];
    assign drive          = positive ? $signed(bounded_narrow) : -$signed(bounded_narrow);

endmodule

// File: hw/rtl/lift_position_controller_core.sv
// Channel   Handshake            Payload
// in        in_valid / in_stall  cmd, right_pot, left_pot, btn_raise .. btn_high
// out       out_valid/ out_stall right_drive, left_drive, right_request, left_request
// cfg       cfg_we               cfg_index, cfg_data (write only)
//
// One transaction per cycle sustained while out_stall is low; three register stages
// (input register, control stage register, drive/request register). Nothing
// iterates, so stalls come only from out_stall.
// Reset (rst_n low) loads the register defaults and zeroes all control state.
// Each stage fills while the one after it stalls, so up to three items sit
// in flight while out_stall is high; results stay put until taken.
module lift_position_controller_core
(
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   cfg_we,
    input  logic [lpc_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [lpc_pkg::CFG_DATA_BITS-1:0]      cfg_data,

    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   cmd,
    input  logic [lpc_pkg::POT_BITS-1:0]           right_pot,
    input  logic [lpc_pkg::POT_BITS-1:0]           left_pot,
    input  logic                                   btn_raise,
    input  logic                                   btn_lower,
    input  logic                                   btn_ground,
    input  logic                                   btn_low,
    input  logic                                   btn_med,
    input  logic                                   btn_high,

    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [lpc_pkg::DRIVE_BITS-1:0]  right_drive,
    output logic signed [lpc_pkg::DRIVE_BITS-1:0]  left_drive,
    output logic signed [lpc_pkg::DRIVE_BITS-1:0]  right_request,
    output logic signed [lpc_pkg::DRIVE_BITS-1:0]  left_request
);

    localparam int PB = lpc_pkg::POT_BITS;
    localparam int EB = lpc_pkg::ERR_BITS;
    localparam int DB = lpc_pkg::DRIVE_BITS;

    localparam logic signed [DB-1:0] DRIVE_MAX = DB'(lpc_pkg::DRIVE_LIMIT);
    localparam logic signed [DB-1:0] DRIVE_MIN = -DB'(lpc_pkg::DRIVE_LIMIT);
    localparam logic signed [DB:0]   RAMP_MAX  = (DB+1)'(lpc_pkg::DRIVE_LIMIT);
    localparam logic signed [DB:0]   RAMP_MIN  = -(DB+1)'(lpc_pkg::DRIVE_LIMIT);

    typedef enum logic [2:0]
    {
        PRESET_MANUAL = 3'd0,
        PRESET_GROUND = 3'd1,
        PRESET_LOW    = 3'd2,
        PRESET_MED    = 3'd3,
        PRESET_HIGH   = 3'd4
    } preset_t;

    typedef enum logic [1:0]
    {
        REQ_HOLD      = 2'd0,
        REQ_FULL_UP   = 2'd1,
        REQ_FULL_DOWN = 2'd2,
        REQ_ZERO      = 2'd3
    } req_mode_t;

    typedef struct packed
    {
        logic raise;
        logic lower;
        logic ground;
        logic low;
        logic med;
        logic high;
    } buttons_t;

    // Configuration registers
    logic [lpc_pkg::GAIN_BITS-1:0]   gain_up_reg;
    logic [lpc_pkg::GAIN_BITS-1:0]   gain_down_reg;
    logic [lpc_pkg::OFFSET_BITS-1:0] left_offset_reg;
    logic [PB-1:0]                   ground_height_reg;
    logic [PB-1:0]                   low_height_reg;
    logic [PB-1:0]                   med_height_reg;
    logic [PB-1:0]                   high_height_reg;
    logic [lpc_pkg::MARGIN_BITS-1:0] safety_margin_reg;

    // Pipeline control
    logic s0_valid_reg;
    logic s1_valid_reg;
    logic out_valid_reg;
    logic s0_ready;
    logic s1_ready;
    logic s2_ready;
    logic s0_move;
    logic s1_move;

    // Stage 0 payload
    logic          s0_cmd_reg;
    logic [PB-1:0] s0_rpot_reg;
    logic [PB-1:0] s0_lpot_reg;
    buttons_t      s0_btn_reg;

    // Stage 1 payload
    logic                 s1_cmd_reg;
    req_mode_t            s1_mode_reg;
    logic signed [EB-1:0] s1_err_r_reg;
    logic signed [EB-1:0] s1_err_l_reg;

    // Control state
    logic [PB-1:0] previous_height_reg;
    logic [PB-1:0] held_height_reg;
    logic [PB-1:0] held_height_next;
    preset_t       preset_reg;
    preset_t       preset_next;
    logic          braking_reg;
    logic          braking_next;

    // Drive state (also the result register)
    logic signed [DB-1:0] right_target_reg;
    logic signed [DB-1:0] left_target_reg;
    logic signed [DB-1:0] right_applied_reg;
    logic signed [DB-1:0] left_applied_reg;
    logic signed [DB-1:0] right_target_next;
    logic signed [DB-1:0] left_target_next;
    logic signed [DB-1:0] right_applied_next;
    logic signed [DB-1:0] left_applied_next;

    // Stage 1 combinational signals
    logic                 stopped;
    logic                 release_latch;
    logic                 near_top;
    logic                 near_bottom;
    logic signed [EB-1:0] top_threshold;
    logic [EB-1:0]        bottom_threshold;
    req_mode_t            mode;
    logic [PB-1:0]        hold_raw;
    logic [PB-1:0]        hold_height;
    logic signed [EB-1:0] err_r;
    logic signed [EB-1:0] err_l;

    // Stage 2 combinational signals
    logic signed [DB-1:0] right_pterm;
    logic signed [DB-1:0] left_pterm;

    // One step toward the target, clamped to the drive limit
    function automatic logic signed [DB-1:0] ramp_step
    (
        input logic signed [DB-1:0] applied,
        input logic signed [DB-1:0] target
    );
        logic signed [DB:0] moved;
        logic signed [DB:0] clamped;
        if (target > applied)
            moved = (DB+1)'(applied) + (DB+1)'(1);
        else if (target < applied)
            moved = (DB+1)'(applied) - (DB+1)'(1);
        else
            moved = (DB+1)'(applied);
        if (moved > RAMP_MAX)
            clamped = RAMP_MAX;
        else if (moved < RAMP_MIN)
            clamped = RAMP_MIN;
        else
            clamped = moved;
        return clamped[DB-1:0];
    endfunction

    // Handshake: each stage accepts when empty or when it empties this cycle
    assign s2_ready = !out_valid_reg || !out_stall;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s0_ready = !s0_valid_reg || s1_ready;
    assign s0_move  = s0_valid_reg && s1_ready;
    assign s1_move  = s1_valid_reg && s2_ready;
    assign in_stall = !s0_ready;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_up_reg       <= lpc_pkg::RST_GAIN_UP;
            gain_down_reg     <= lpc_pkg::RST_GAIN_DOWN;
            left_offset_reg   <= lpc_pkg::RST_LEFT_OFFSET;
            ground_height_reg <= lpc_pkg::RST_GROUND_HEIGHT;
            low_height_reg    <= lpc_pkg::RST_LOW_HEIGHT;
            med_height_reg    <= lpc_pkg::RST_MED_HEIGHT;
            high_height_reg   <= lpc_pkg::RST_HIGH_HEIGHT;
            safety_margin_reg <= lpc_pkg::RST_SAFETY_MARGIN;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lpc_pkg::REG_GAIN_UP:
                    gain_up_reg <= cfg_data[lpc_pkg::GAIN_BITS-1:0];
                lpc_pkg::REG_GAIN_DOWN:
                    gain_down_reg <= cfg_data[lpc_pkg::GAIN_BITS-1:0];
                lpc_pkg::REG_LEFT_OFFSET:
                    left_offset_reg <= cfg_data[lpc_pkg::OFFSET_BITS-1:0];
                lpc_pkg::REG_GROUND_HEIGHT:
                    ground_height_reg <= cfg_data[PB-1:0];
                lpc_pkg::REG_LOW_HEIGHT:
                    low_height_reg <= cfg_data[PB-1:0];
                lpc_pkg::REG_MED_HEIGHT:
                    med_height_reg <= cfg_data[PB-1:0];
                lpc_pkg::REG_HIGH_HEIGHT:
                    high_height_reg <= cfg_data[PB-1:0];
                lpc_pkg::REG_SAFETY_MARGIN:
                    safety_margin_reg <= cfg_data[lpc_pkg::MARGIN_BITS-1:0];
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk)
    begin
        if (s0_ready)
        begin
            s0_cmd_reg  <= cmd;
            s0_rpot_reg <= right_pot;
            s0_lpot_reg <= left_pot;
            s0_btn_reg  <= '{raise: btn_raise, lower: btn_lower, ground: btn_ground,
                             low: btn_low, med: btn_med, high: btn_high};
        end
    end

    // Control stage: next control state
    assign stopped       = (s0_rpot_reg == previous_height_reg);
    assign release_latch = !s0_btn_reg.raise && !s0_btn_reg.lower &&
                           (preset_reg == PRESET_MANUAL) && braking_reg && stopped;

    always_comb
    begin
        if (s0_btn_reg.ground)
            preset_next = PRESET_GROUND;
        else if (s0_btn_reg.low)
            preset_next = PRESET_LOW;
        else if (s0_btn_reg.med)
            preset_next = PRESET_MED;
        else if (s0_btn_reg.high)
            preset_next = PRESET_HIGH;
        else if (s0_btn_reg.raise || s0_btn_reg.lower)
            preset_next = PRESET_MANUAL;
        else
            preset_next = preset_reg;

        if (s0_btn_reg.raise || s0_btn_reg.lower)
            braking_next = 1'b1;
        else if (release_latch)
            braking_next = 1'b0;
        else
            braking_next = braking_reg;

        held_height_next = release_latch ? s0_rpot_reg : held_height_reg;
    end

    // End stop windows, signed so a margin above the top height still works
    assign top_threshold    = $signed({2'b00, high_height_reg}) -
                              $signed(EB'(safety_margin_reg));
    assign bottom_threshold = EB'(ground_height_reg) + EB'(safety_margin_reg);
    assign near_top         = $signed({2'b00, s0_rpot_reg}) > top_threshold;
    assign near_bottom      = EB'(s0_rpot_reg) < bottom_threshold;

    // Request kind and raw hold height; a preset overrides manual drive
    always_comb
    begin
        mode     = REQ_ZERO;
        hold_raw = held_height_reg;
        if (preset_next != PRESET_MANUAL)
        begin
            mode = REQ_HOLD;
            unique case (preset_next)
                PRESET_GROUND: hold_raw = ground_height_reg;
                PRESET_LOW:    hold_raw = low_height_reg;
                PRESET_MED:    hold_raw = med_height_reg;
                default:       hold_raw = high_height_reg;
            endcase
        end
        else if (s0_btn_reg.raise)
        begin
            mode     = near_top ? REQ_HOLD : REQ_FULL_UP;
            hold_raw = high_height_reg;
        end
        else if (s0_btn_reg.lower)
        begin
            mode     = near_bottom ? REQ_HOLD : REQ_FULL_DOWN;
            hold_raw = ground_height_reg;
        end
        else if (!braking_reg && (held_height_reg != '0))
        begin
            mode = REQ_HOLD;
        end
    end

    // Bound the hold height, then form both side errors
    always_comb
    begin
        if (hold_raw > high_height_reg)
            hold_height = high_height_reg;
        else if (hold_raw < ground_height_reg)
            hold_height = ground_height_reg;
        else
            hold_height = hold_raw;
    end

    assign err_r = $signed(EB'(hold_height)) - $signed(EB'(s0_rpot_reg));
    assign err_l = $signed(EB'(hold_height)) - $signed(EB'(s0_lpot_reg)) +
                   $signed({{(EB-lpc_pkg::OFFSET_BITS){left_offset_reg[lpc_pkg::OFFSET_BITS-1]}},
                            left_offset_reg});

    // Control state and stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg        <= 1'b0;
            s1_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            previous_height_reg <= '0;
            held_height_reg     <= '0;
            preset_reg          <= PRESET_MANUAL;
            braking_reg         <= 1'b0;
        end
        else
        begin
            if (s0_ready)
                s0_valid_reg <= in_valid;
            if (s1_ready)
                s1_valid_reg <= s0_valid_reg;
            if (s2_ready)
                out_valid_reg <= s1_valid_reg;
            if (s0_move && !s0_cmd_reg)
            begin
                previous_height_reg <= s0_rpot_reg;
                held_height_reg     <= held_height_next;
                preset_reg          <= preset_next;
                braking_reg         <= braking_next;
            end
        end
    end

    // Control stage register
    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_cmd_reg   <= s0_cmd_reg;
            s1_mode_reg  <= mode;
            s1_err_r_reg <= err_r;
            s1_err_l_reg <= err_l;
        end
    end

    // Result stage: proportional terms
    lpc_p_term u_p_right
    (
        .err       (s1_err_r_reg),
        .gain_up   (gain_up_reg),
        .gain_down (gain_down_reg),
        .drive     (right_pterm)
    );

    lpc_p_term u_p_left
    (
        .err       (s1_err_l_reg),
        .gain_up   (gain_up_reg),
        .gain_down (gain_down_reg),
        .drive     (left_pterm)
    );

    // Ramp tick moves the applied drives, control tick sets the requests
    always_comb
    begin
        right_target_next  = right_target_reg;
        left_target_next   = left_target_reg;
        right_applied_next = right_applied_reg;
        left_applied_next  = left_applied_reg;
        if (s1_cmd_reg)
        begin
            right_applied_next = ramp_step(right_applied_reg, right_target_reg);
            left_applied_next  = ramp_step(left_applied_reg, left_target_reg);
        end
        else
        begin
            unique case (s1_mode_reg)
                REQ_HOLD:
                begin
                    right_target_next = right_pterm;
                    left_target_next  = left_pterm;
                end
                REQ_FULL_UP:
                begin
                    right_target_next = DRIVE_MAX;
                    left_target_next  = DRIVE_MAX;
                end
                REQ_FULL_DOWN:
                begin
                    right_target_next = DRIVE_MIN;
                    left_target_next  = DRIVE_MIN;
                end
                REQ_ZERO:
                begin
                    right_target_next = '0;
                    left_target_next  = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            right_target_reg  <= '0;
            left_target_reg   <= '0;
            right_applied_reg <= '0;
            left_applied_reg  <= '0;
        end
        else if (s1_move)
        begin
            right_target_reg  <= right_target_next;
            left_target_reg   <= left_target_next;
            right_applied_reg <= right_applied_next;
            left_applied_reg  <= left_applied_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign right_drive   = right_applied_reg;
    assign left_drive    = left_applied_reg;
    assign right_request = right_target_reg;
    assign left_request  = left_target_reg;

    // Ramp ticks never touch the requests
    a_ramp_keeps_request: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move && s1_cmd_reg |=> $stable(right_target_reg) && $stable(left_target_reg))
        else $error("request changed on a ramp tick");

    // Control ticks never touch the applied drives
    a_ctrl_keeps_applied: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move && !s1_cmd_reg |=> $stable(right_applied_reg) && $stable(left_applied_reg))
        else $error("applied drive changed on a control tick");

    // Right applied drive moves by at most one step per transaction
    a_ramp_single_step: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move |=> (right_applied_reg == $past(right_applied_reg) ||
                     right_applied_reg == $past(right_applied_reg) + DB'(1) ||
                     right_applied_reg == $past(right_applied_reg) - DB'(1)))
        else $error("right applied drive jumped");

    // The hold height is latched only when braking ends
    a_latch_on_release: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(held_height_reg) |-> $fell(braking_reg))
        else $error("hold height changed outside a brake release");

endmodule
